[src/rwt_pkg.sv]
// Shared constants and types of the retransmit window tracker.
package rwt_pkg;

	// Entry store size; ENTRY_COUNT is a power of two
	localparam int ENTRY_COUNT = 1024;
	localparam int ADDR_BITS   = $clog2(ENTRY_COUNT);

	// Width of head and length inside the entry store
	localparam int OFFSET_BITS = 16;

	// Fixed widths of the channel fields
	localparam int MSG_ID_BITS    = 10;
	localparam int FIELD_OFS_BITS = 16;

	// Receive window and time stamps
	localparam int WIN_BITS     = 64;
	localparam int WIN_IDX_BITS = $clog2(WIN_BITS);
	localparam int RUN_BITS     = $clog2(WIN_BITS) + 1;
	localparam int STAMP_BITS   = 64;

	// Resend cutoff register
	localparam int          CUTOFF_BITS  = 32;
	localparam logic [31:0] CUTOFF_RESET = 32'd200000;

	// Item and result codes
	localparam logic OP_TOUCH    = 1'b0;
	localparam logic OP_SCAN     = 1'b1;
	localparam logic KIND_DONE   = 1'b0;
	localparam logic KIND_RESEND = 1'b1;

	// One entry of the message store
	typedef struct packed {
		logic [STAMP_BITS-1:0]  stamp;
		logic [WIN_BITS-1:0]    win;
		logic [OFFSET_BITS-1:0] head;
		logic [OFFSET_BITS-1:0] len;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

[src/rwt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/rwt_run_unit.sv]
// Multi-cycle search for the run of received packets at the bottom of a window.
module rwt_run_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rwt_pkg::WIN_BITS-1:0] win_in,
	output logic                         done,
	output logic [rwt_pkg::WIN_BITS-1:0] win_out,
	output logic [rwt_pkg::RUN_BITS-1:0] shift
);

	import rwt_pkg::*;

	localparam int STEP     = 8;
	localparam int STEP_IDX = $clog2(STEP);

	logic                busy_q;
	logic                done_q;
	logic [WIN_BITS-1:0] win_q;
	logic [RUN_BITS-1:0] cnt_q;
	logic [STEP_IDX:0]   ones;
	logic                last;
	logic                stop;

	// Trailing ones of the low byte
	always_comb begin
		ones = '0;
		stop = 1'b0;
		for (int i = 0; i < STEP; i++) begin
			if (!stop && win_q[i]) begin
				ones = ones + 1'b1;
			end else begin
				stop = 1'b1;
			end
		end
		last = (win_q[STEP-1:0] != {STEP{1'b1}});
	end

	// Control: busy while whole bytes of ones are being dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last && !start;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Window shifts down one byte a step, then by the partial run
	always_ff @(posedge clk) begin
		if (start) begin
			win_q <= win_in;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (last) begin
				win_q <= win_q >> ones[STEP_IDX-1:0];
				cnt_q <= cnt_q + RUN_BITS'(ones);
			end else begin
				win_q <= win_q >> STEP;
				cnt_q <= cnt_q + RUN_BITS'(STEP);
			end
		end
	end

	assign done    = done_q;
	assign win_out = win_q;
	assign shift   = cnt_q;

endmodule

[src/retransmit_window_tracker.sv]
// Top level of the retransmit window tracker: sequencer, entry store and result register.
//
// Input channel (in_valid / in_stall) carries one item per transfer: a touch
// (op = OP_TOUCH) that marks a packet of message msg_id as received, or a scan
// step (op = OP_SCAN) that checks the next entry of a wrapping crawl for a
// resend. Output channel (out_valid / out_stall) carries a completion or a
// resend request; at most one per item, held in an output register.
// cfg_we / cfg_wdata write the resend cutoff in ticks.
// One item is worked at a time, read-modify-write on a single entry RAM:
//   scan: read, then write-back;
//   touch outside the window: read only, with no write-back;
//   touch inside the window: read, run search, then write-back; the run
//   search drops one byte of received packets per cycle.
// A result shows on out_valid the cycle after the write-back; the next item
// can be taken in that same cycle.
// After reset the store is swept to zero, one entry per cycle, all ENTRY_COUNT
// entries (1024) with in_stall high; cfg writes are taken during the sweep.
// While the receiver stalls, a pending result holds; the next item is still
// taken and worked, and only waits at write-back if it has a result too.
module retransmit_window_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rwt_pkg::CUTOFF_BITS-1:0]    cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic [rwt_pkg::MSG_ID_BITS-1:0]    msg_id,
	input  logic                               init,
	input  logic [rwt_pkg::FIELD_OFS_BITS-1:0] pkt_offset,
	input  logic [rwt_pkg::FIELD_OFS_BITS-1:0] msg_length,
	input  logic                               egress_ready,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               kind,
	output logic [rwt_pkg::MSG_ID_BITS-1:0]    out_id,
	output logic [rwt_pkg::FIELD_OFS_BITS-1:0] resend_from
);

	import rwt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_RUN,
		S_WB
	} state_t;

	state_t state_q;

	// Configuration and global state
	logic [CUTOFF_BITS-1:0] cutoff_q;
	logic [STAMP_BITS-1:0]  now_q;
	logic [ADDR_BITS-1:0]   scan_q;
	logic                   clr_busy_q;
	logic [ADDR_BITS-1:0]   clr_addr_q;

	// Item being worked
	logic                   op_q;
	logic [ADDR_BITS-1:0]   id_q;
	logic                   init_q;
	logic [OFFSET_BITS-1:0] ofs_q;
	logic [OFFSET_BITS-1:0] len_in_q;
	logic                   ready_q;
	entry_t                 ent_q;
	logic [STAMP_BITS-1:0]  age_q;
	logic                   stamp_nz_q;

	// Result register
	logic                      out_valid_q;
	logic                      kind_q;
	logic [ADDR_BITS-1:0]      out_addr_q;
	logic [OFFSET_BITS-1:0]    from_q;

	// RAM ports
	logic                   ram_we;
	logic [ADDR_BITS-1:0]   ram_waddr;
	entry_t                 ram_wdata;
	logic                   ram_re;
	logic [ADDR_BITS-1:0]   ram_raddr;
	entry_t                 rd;

	// Run unit
	logic                   run_start;
	logic                   run_done;
	logic [WIN_BITS-1:0]    run_win;
	logic [RUN_BITS-1:0]    run_shift;

	// Field adaptation between channel widths and store widths
	logic [MSG_ID_BITS+ADDR_BITS-1:0]      id_in_ext;
	logic [ADDR_BITS+MSG_ID_BITS-1:0]      id_out_ext;
	logic [OFFSET_BITS+FIELD_OFS_BITS-1:0] ofs_in_ext;
	logic [OFFSET_BITS+FIELD_OFS_BITS-1:0] len_in_ext;
	logic [FIELD_OFS_BITS+OFFSET_BITS-1:0] from_ext;

	// Read stage decode of a touch
	logic [WIN_BITS-1:0]    win0;
	logic [OFFSET_BITS-1:0] head0;
	logic [OFFSET_BITS-1:0] len0;
	logic [OFFSET_BITS:0]   delta;
	logic [OFFSET_BITS:0]   dist_m1;
	logic                   in_win;
	logic [WIN_BITS-1:0]    win_set;

	// Write-back decisions
	logic                   msg_done;
	logic                   due;
	logic                   has_result;
	logic                   out_free;
	logic                   wb_go;
	logic                   accept;

	assign id_in_ext  = {{ADDR_BITS{1'b0}}, msg_id};
	assign ofs_in_ext = {{OFFSET_BITS{1'b0}}, pkt_offset};
	assign len_in_ext = {{OFFSET_BITS{1'b0}}, msg_length};
	assign id_out_ext = {{MSG_ID_BITS{1'b0}}, out_addr_q};
	assign from_ext   = {{FIELD_OFS_BITS{1'b0}}, from_q};

	assign accept   = in_valid && !in_stall;
	assign in_stall = clr_busy_q || (state_q != S_IDLE);

	// Touch decode on the freshly read entry
	always_comb begin
		win0    = init_q ? '0 : rd.win;
		head0   = init_q ? '0 : rd.head;
		len0    = init_q ? len_in_q : rd.len;
		delta   = {1'b0, ofs_q} - {1'b0, head0};
		dist_m1 = delta - 1'b1;
		in_win  = (ofs_q > head0) && (delta <= (OFFSET_BITS+1)'(WIN_BITS));
		win_set = win0 | (WIN_BITS'(1) << dist_m1[WIN_IDX_BITS-1:0]);
	end

	assign run_start = (state_q == S_READ) && (op_q == OP_TOUCH) && in_win;

	// Write-back decisions
	always_comb begin
		msg_done   = (ent_q.head == ent_q.len);
		due        = stamp_nz_q && (age_q >= STAMP_BITS'(cutoff_q)) && ready_q;
		has_result = (op_q == OP_TOUCH) ? msg_done : due;
		out_free   = !out_valid_q || !out_stall;
		wb_go      = (state_q == S_WB) && (!has_result || out_free);
	end

	// RAM port selection: clearing sweep has the write port first
	always_comb begin
		ram_re    = accept;
		ram_raddr = (op == OP_SCAN) ? scan_q : id_in_ext[ADDR_BITS-1:0];
		ram_we    = 1'b0;
		ram_waddr = id_q;
		ram_wdata = ent_q;
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (wb_go) begin
			if (op_q == OP_TOUCH) begin
				ram_we          = 1'b1;
				ram_wdata.stamp = msg_done ? '0 : now_q;
			end else begin
				ram_we          = due;
				ram_wdata.stamp = now_q;
			end
		end
	end

	rwt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (ENTRY_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	rwt_run_unit u_run (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (run_start),
		.win_in  (win_set),
		.done    (run_done),
		.win_out (run_win),
		.shift   (run_shift)
	);

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_BITS'(ENTRY_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Cutoff register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg_we) begin
			cutoff_q <= cfg_wdata;
		end
	end

	// Sequencer, time, scan pointer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// new result wins over the transfer of the old one
			if (wb_go && has_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (op_q == OP_SCAN) begin
						state_q <= S_WB;
					end else if (in_win) begin
						state_q <= S_RUN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RUN: begin
					if (run_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wb_go) begin
						state_q <= S_IDLE;
						now_q   <= now_q + 1'b1;
						if (op_q == OP_SCAN) begin
							scan_q <= (scan_q == ADDR_BITS'(ENTRY_COUNT - 1)) ?
								'0 : scan_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload, entry image and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			id_q     <= (op == OP_SCAN) ? scan_q : id_in_ext[ADDR_BITS-1:0];
			init_q   <= init;
			ofs_q    <= ofs_in_ext[OFFSET_BITS-1:0];
			len_in_q <= len_in_ext[OFFSET_BITS-1:0];
			ready_q  <= egress_ready;
		end
		if (state_q == S_READ) begin
			age_q      <= now_q - rd.stamp;
			stamp_nz_q <= (rd.stamp != '0);
			if (op_q == OP_TOUCH) begin
				ent_q <= '{stamp: rd.stamp, win: win_set, head: head0, len: len0};
			end else begin
				ent_q <= rd;
			end
		end
		if ((state_q == S_RUN) && run_done) begin
			ent_q <= '{stamp: ent_q.stamp, win: run_win,
				head: ent_q.head + OFFSET_BITS'(run_shift), len: ent_q.len};
		end
		if (wb_go && has_result) begin
			out_addr_q <= id_q;
			if (op_q == OP_TOUCH) begin
				kind_q <= KIND_DONE;
				from_q <= '0;
			end else begin
				kind_q <= KIND_RESEND;
				from_q <= ent_q.head + 1'b1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_id      = id_out_ext[MSG_ID_BITS-1:0];
	assign resend_from = from_ext[FIELD_OFS_BITS-1:0];

endmodule

[src/rwt_checker.sv]
// Port-level checks of the retransmit window tracker, bound to the top level.
module rwt_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               kind,
	input logic [rwt_pkg::MSG_ID_BITS-1:0]    out_id,
	input logic [rwt_pkg::FIELD_OFS_BITS-1:0] resend_from
);

	import rwt_pkg::*;

	// A stalled result holds until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_id)
			&& $stable(resend_from))
		else $error("stalled result changed");

	// A completion carries no resend offset
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DONE) |-> (resend_from == '0))
		else $error("completion with nonzero resend_from");

	// One item at a time: the cycle after a transfer takes no input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// A new result comes only out of write-back, when input is stalled
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

endmodule

bind retransmit_window_tracker rwt_checker u_rwt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.kind        (kind),
	.out_id      (out_id),
	.resend_from (resend_from)
);
